// ----- design/ilcp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ilcp_pkg;

    // request operation codes
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // decoded request kinds
    localparam logic [2:0] KIND_REJECT = 3'd0;
    localparam logic [2:0] KIND_MISS   = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_APPEND = 3'd3;
    localparam logic [2:0] KIND_INSERT = 3'd4;
    localparam logic [2:0] KIND_REMOVE = 3'd5;

    localparam logic [8:0] CAP_LIMIT = 9'd511;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic accept;
        logic decode;
        logic grow;
        logic app_wr;
        logic rd_idx;
        logic rd_capture;
        logic ptr_ld_ins;
        logic ptr_ld_rem;
        logic rd_dn;
        logic wr_ins;
        logic ins_final;
        logic rd_up;
        logic wr_rem;
        logic rem_final;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       ptr_at_idx;
        logic       rem_more;
        logic       out_free;
    } stat_t;

    // floor(x / 3) for x below 1024, by reciprocal multiply
    function automatic logic [8:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd683;
        return prod[19:11];
    endfunction

endpackage

`default_nettype wire

// ----- design/ilcp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilcp_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ilcp_pkg::stat_t stat,
    output ilcp_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_RD_DATA = 3'd2;
    localparam logic [2:0] S_INS_RD  = 3'd3;
    localparam logic [2:0] S_INS_WR  = 3'd4;
    localparam logic [2:0] S_REM_RD  = 3'd5;
    localparam logic [2:0] S_REM_WR  = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                case (stat.kind)
                    ilcp_pkg::KIND_APPEND: begin
                        cmd.grow   = 1'b1;
                        cmd.app_wr = 1'b1;
                        state_next = S_RESP;
                    end
                    ilcp_pkg::KIND_INSERT: begin
                        cmd.grow       = 1'b1;
                        cmd.ptr_ld_ins = 1'b1;
                        state_next     = S_INS_RD;
                    end
                    ilcp_pkg::KIND_READ: begin
                        cmd.rd_idx = 1'b1;
                        state_next = S_RD_DATA;
                    end
                    ilcp_pkg::KIND_REMOVE: begin
                        cmd.ptr_ld_rem = 1'b1;
                        state_next     = S_REM_RD;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RD_DATA: begin
                cmd.rd_capture = 1'b1;
                state_next     = S_RESP;
            end
            S_INS_RD: begin
                // walk down from the tail until the gap reaches the index
                if (stat.ptr_at_idx) begin
                    cmd.ins_final = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    cmd.rd_dn  = 1'b1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                cmd.wr_ins = 1'b1;
                state_next = S_INS_RD;
            end
            S_REM_RD: begin
                if (stat.rem_more) begin
                    cmd.rd_up  = 1'b1;
                    state_next = S_REM_WR;
                end else begin
                    cmd.rem_final = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_REM_WR: begin
                cmd.wr_rem = 1'b1;
                state_next = S_REM_RD;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/ilcp_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilcp_dpath #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MIN_CAPACITY = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [ilcp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire ilcp_pkg::cmd_t                      cmd,
    output ilcp_pkg::stat_t                          stat,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [ilcp_pkg::OUT_DATA_W-1:0]          m_tdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [8:0]    MIN_CAP = 9'(MIN_CAPACITY);
    localparam logic [XW-1:0] MAX_X   = XW'(MAX_ENTRIES);

    logic [1:0]    mode_reg;
    logic [8:0]    idx_reg;
    logic [30:0]   val_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [8:0]    cap_reg;
    logic [8:0]    cap_next;
    logic [XW-1:0] ptr_reg;
    logic [XW-1:0] ptr_next;
    logic [1:0]    res_status_reg;
    logic [31:0]   res_rd_reg;
    logic [30:0]   mem_rdata_reg;
    logic          m_tvalid_reg;
    logic [ilcp_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [30:0]   mem [MAX_ENTRIES];

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] ptr_dn;
    logic [XW-1:0] ptr_up;
    logic          is_full;
    logic [2:0]    dec_kind;
    logic [1:0]    dec_status;
    logic [9:0]    cap_dbl;
    logic [8:0]    cap_grown;
    logic [CW-1:0] cnt_dec;
    logic [8:0]    cap_third;
    logic [8:0]    cap_shrunk;
    logic [CW+8:0] cnt_wide;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [30:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign cnt_x   = XW'(count_reg);
    assign idx_x   = XW'(idx_reg);
    assign cap_x   = XW'(cap_reg);
    assign ptr_dn  = ptr_reg - XW'(1);
    assign ptr_up  = ptr_reg + XW'(1);
    assign is_full = (cnt_x >= MAX_X);

    // request decode against the current count and capacity
    always_comb begin
        dec_kind   = ilcp_pkg::KIND_REJECT;
        dec_status = ilcp_pkg::ST_OK;
        case (mode_reg)
            ilcp_pkg::MODE_READ: begin
                if (idx_x >= cap_x) begin
                    dec_status = ilcp_pkg::ST_RANGE;
                end else if (idx_x >= cnt_x) begin
                    dec_kind = ilcp_pkg::KIND_MISS;
                end else begin
                    dec_kind = ilcp_pkg::KIND_READ;
                end
            end
            ilcp_pkg::MODE_APPEND: begin
                if (is_full) begin
                    dec_status = ilcp_pkg::ST_FULL;
                end else begin
                    dec_kind = ilcp_pkg::KIND_APPEND;
                end
            end
            ilcp_pkg::MODE_INSERT: begin
                // insert at the count is an append, whatever the capacity
                if (idx_x == cnt_x) begin
                    if (is_full) begin
                        dec_status = ilcp_pkg::ST_FULL;
                    end else begin
                        dec_kind = ilcp_pkg::KIND_APPEND;
                    end
                end else if (idx_x >= cap_x || idx_x > cnt_x) begin
                    dec_status = ilcp_pkg::ST_RANGE;
                end else if (is_full) begin
                    dec_status = ilcp_pkg::ST_FULL;
                end else begin
                    dec_kind = ilcp_pkg::KIND_INSERT;
                end
            end
            ilcp_pkg::MODE_REMOVE: begin
                if (idx_x >= cap_x || idx_x >= cnt_x) begin
                    dec_status = ilcp_pkg::ST_RANGE;
                end else begin
                    dec_kind = ilcp_pkg::KIND_REMOVE;
                end
            end
            default: begin
                dec_status = ilcp_pkg::ST_RANGE;
            end
        endcase
    end

    // capacity policy: double when full (at most CAP_LIMIT), two thirds when under half (at least MIN_CAP)
    assign cap_dbl   = {cap_reg, 1'b0};
    assign cap_grown = (cnt_x >= cap_x)
                     ? ((cap_dbl > 10'(ilcp_pkg::CAP_LIMIT)) ? ilcp_pkg::CAP_LIMIT : cap_dbl[8:0])
                     : cap_reg;
    assign cnt_dec    = count_reg - CW'(1);
    assign cap_third  = ilcp_pkg::div3(cap_dbl);
    assign cap_shrunk = ((XW'(cnt_dec) < XW'(cap_reg >> 1)) && (cap_reg != MIN_CAP))
                      ? ((cap_third < MIN_CAP) ? MIN_CAP : cap_third)
                      : cap_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.app_wr || cmd.ins_final) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.rem_final) begin
            count_next = cnt_dec;
        end
    end

    always_comb begin
        cap_next = cap_reg;
        if (cmd.grow) begin
            cap_next = cap_grown;
        end else if (cmd.rem_final) begin
            cap_next = cap_shrunk;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_ld_ins) begin
            ptr_next = cnt_x;
        end else if (cmd.ptr_ld_rem) begin
            ptr_next = idx_x;
        end else if (cmd.wr_ins) begin
            ptr_next = ptr_dn;
        end else if (cmd.wr_rem) begin
            ptr_next = ptr_up;
        end
    end

    // single write port, single registered read port
    assign wr_en = cmd.app_wr | cmd.wr_ins | cmd.ins_final | cmd.wr_rem;

    always_comb begin
        wr_addr = ptr_reg[AW-1:0];
        wr_data = mem_rdata_reg;
        if (cmd.app_wr) begin
            wr_addr = cnt_x[AW-1:0];
            wr_data = val_reg;
        end else if (cmd.ins_final) begin
            wr_addr = idx_x[AW-1:0];
            wr_data = val_reg;
        end
    end

    assign rd_en = cmd.rd_idx | cmd.rd_dn | cmd.rd_up;

    always_comb begin
        rd_addr = idx_x[AW-1:0];
        if (cmd.rd_dn) begin
            rd_addr = ptr_dn[AW-1:0];
        end else if (cmd.rd_up) begin
            rd_addr = ptr_up[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    // request and result holding registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_tdata[1:0];
            idx_reg  <= s_tdata[10:2];
            val_reg  <= s_tdata[41:11];
        end
        if (cmd.decode) begin
            res_status_reg <= dec_status;
            res_rd_reg     <= (dec_kind == ilcp_pkg::KIND_MISS) ? '1 : '0;
        end else if (cmd.rd_capture) begin
            res_rd_reg <= {1'b0, mem_rdata_reg};
        end
        ptr_reg <= ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= MIN_CAP;
        end else begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    // output register
    assign cnt_wide = {9'b0, count_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {4'b0, cap_reg, cnt_wide[8:0], res_rd_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.kind       = dec_kind;
    assign stat.ptr_at_idx = (ptr_reg == idx_x);
    assign stat.rem_more   = (ptr_up < cnt_x);
    assign stat.out_free   = out_free;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_x <= MAX_X)
        else $error("entry count beyond store depth");

    a_cap_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg >= MIN_CAP)
        else $error("capacity below minimum");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.app_wr, cmd.wr_ins, cmd.ins_final, cmd.wr_rem}))
        else $error("more than one store write source");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over an unaccepted result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.app_wr || cmd.ins_final) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("count did not advance after a store write");

endmodule

`default_nettype wire

// ----- design/indexed_list_with_capacity_policy.sv -----
// Indexed list with a logical capacity policy.
//
// Requests arrive on the s_ stream channel (mode, index, value) and each gives
// exactly one result on the m_ channel (status, read value, entry count and
// logical capacity after the request). One request is worked on at a time.
// After a request is accepted it is decoded; then, by kind:
//   read hit                       reads the entry at the index
//   read miss, append, rejection   nothing more (an append writes in decode)
//   insert at index i              shifts entries i..count-1 up, writes value
//   remove at index i              shifts entries i+1..count-1 down
// Every kind ends by loading the result. Insert and remove move one entry at
// a time through the single read and write port of the entry store, reading
// it and then writing it one place over; that shift loop sets the rate.
// The next request is taken in the cycle after the result is loaded, and
// not before.
// The result sits in an output register: while the receiver stalls, the
// block still takes and works on the next request, and holds its result
// until the register is free.
// Reset clears the count to zero and the capacity to MIN_CAPACITY; the entry
// store is not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_with_capacity_policy #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MIN_CAPACITY = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // mode[1:0], index[10:2], value[41:11], zero fill
    input  wire logic [ilcp_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[1:0], read_value[33:2], entry_count[42:34],
    // logical_capacity[51:43], zero fill
    output logic [ilcp_pkg::OUT_DATA_W-1:0]      m_tdata
);

    ilcp_pkg::cmd_t  cmd;
    ilcp_pkg::stat_t stat;

    ilcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ilcp_dpath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MIN_CAPACITY (MIN_CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
